@@ rtl/core/hsc_pkg.sv @@
// Shared constants, types and codes for the five-point heat stencil core.
`default_nettype none

package hsc_pkg;

    // Sizing of the grid and of the values.
    localparam int MAX_WIDTH     = 1024;
    localparam int VALUE_BITS    = 48;
    localparam int LINE_DEPTH    = MAX_WIDTH + 2;
    localparam int COL_BITS      = $clog2(LINE_DEPTH);
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int HEAT_BITS     = 64;
    localparam int SUM_BITS      = VALUE_BITS + 2;
    localparam int ENTRY_BITS    = 3 * VALUE_BITS;

    // Configuration port.
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_HEIGHT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COL_BITS-1:0]   col_t;

    // Position decode of one accepted word, from the sequencer to the datapath.
    typedef struct packed {
        col_t col;
        logic interior;
        logic last;
        logic restart;
    } pos_t;

endpackage

`default_nettype wire

@@ rtl/core/hsc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1026
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/hsc_ctrl.sv @@
// Configuration registers and raster position sequencer of the stencil core.
`default_nettype none

module hsc_ctrl (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [hsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [hsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic                                  accept,
    output hsc_pkg::pos_t                              pos
);

    logic [hsc_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [hsc_pkg::HEIGHT_BITS-1:0] height_reg;
    hsc_pkg::col_t                   col_reg;
    hsc_pkg::col_t                   col_next;
    logic [hsc_pkg::HEIGHT_BITS-1:0] row_reg;
    logic [hsc_pkg::HEIGHT_BITS-1:0] row_next;
    hsc_pkg::col_t                   w_eff;
    logic [hsc_pkg::HEIGHT_BITS-1:0] h_eff;
    logic [hsc_pkg::HEIGHT_BITS-1:0] h_last;
    logic                            row_end;

    // Configuration writes; data is truncated to the register width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hsc_pkg::WIDTH_RESET;
            height_reg <= hsc_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hsc_pkg::REG_BLOCK_WIDTH:  width_reg  <= cfg_data[hsc_pkg::WIDTH_BITS-1:0];
                hsc_pkg::REG_BLOCK_HEIGHT: height_reg <= cfg_data[hsc_pkg::HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the block size into its legal range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = hsc_pkg::COL_BITS'(1);
        end
        else if (32'(width_reg) > hsc_pkg::MAX_WIDTH)
        begin
            w_eff = hsc_pkg::COL_BITS'(hsc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = hsc_pkg::COL_BITS'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = hsc_pkg::HEIGHT_BITS'(1);
        end
        else if (32'(height_reg) > hsc_pkg::HEIGHT_LIMIT)
        begin
            h_eff = hsc_pkg::HEIGHT_BITS'(hsc_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
        h_last = h_eff + hsc_pkg::HEIGHT_BITS'(1);
    end

    // Decode the current position: a word here completes the stencil of the
    // point one row up when it lies below the top halo and inside the columns.
    always_comb
    begin
        row_end      = ({1'b0, col_reg} >= ({1'b0, w_eff} + (hsc_pkg::COL_BITS+1)'(1)));
        pos.col      = col_reg;
        pos.interior = (row_reg >= hsc_pkg::HEIGHT_BITS'(2)) && (row_reg <= h_last) &&
                       (col_reg != '0) && (col_reg <= w_eff);
        pos.last     = (row_reg == h_last) && (col_reg == w_eff);
        pos.restart  = (row_reg == hsc_pkg::HEIGHT_BITS'(2)) &&
                       (col_reg == hsc_pkg::COL_BITS'(1));

        if (row_end)
        begin
            col_next = '0;
            row_next = (row_reg >= h_last) ? '0 : row_reg + hsc_pkg::HEIGHT_BITS'(1);
        end
        else
        begin
            col_next = col_reg + hsc_pkg::COL_BITS'(1);
            row_next = row_reg;
        end
    end

    // Raster counters advance once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef ASSERT_OFF
    // The column counter always addresses a line buffer entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < hsc_pkg::LINE_DEPTH)
        else $error("column counter beyond line buffer depth");

    // The row counter never passes the bottom halo of the tallest frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) <= hsc_pkg::HEIGHT_LIMIT + 1)
        else $error("row counter beyond the tallest frame");

    // The final point of a frame is always an interior point.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos.last |-> pos.interior)
        else $error("last point flagged outside the interior");
`endif

endmodule

`default_nettype wire

@@ rtl/core/hsc_datapath.sv @@
// Line buffer memories, stencil arithmetic pipeline and heat accumulator.
`default_nettype none

module hsc_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire hsc_pkg::value_t                old_value,
    input  wire hsc_pkg::value_t                prior_value,
    input  wire hsc_pkg::pos_t                  pos,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output hsc_pkg::value_t                     new_value,
    output logic [hsc_pkg::HEAT_BITS-1:0]       heat_total,
    output logic                                last_point
);

    // Stage 1: line buffer read data returns.
    logic                            v1_reg;
    hsc_pkg::pos_t                   pos1_reg;
    hsc_pkg::value_t                 old1_reg;
    hsc_pkg::value_t                 prior1_reg;
    hsc_pkg::value_t                 west_reg;
    // Stage 2: neighbour sum.
    logic                            v2_reg;
    logic [hsc_pkg::SUM_BITS-1:0]    sum2_reg;
    hsc_pkg::value_t                 cprior2_reg;
    logic                            last2_reg;
    logic                            restart2_reg;
    // Stage 3: new value.
    logic                            v3_reg;
    hsc_pkg::value_t                 nv3_reg;
    logic                            last3_reg;
    logic                            restart3_reg;
    // Output stage.
    logic                            out_valid_reg;
    hsc_pkg::value_t                 new_value_reg;
    logic [hsc_pkg::HEAT_BITS-1:0]   heat_reg;
    logic                            last_reg;

    logic                            ready_out;
    logic                            ready3;
    logic                            ready2;
    logic                            ready1;
    logic                            accept;
    logic                            adv1;
    logic                            out_load;

    logic [hsc_pkg::ENTRY_BITS-1:0]  e_rdata;
    logic [hsc_pkg::ENTRY_BITS-1:0]  e_wdata;
    hsc_pkg::value_t                 m_rdata;
    hsc_pkg::col_t                   m_raddr;
    hsc_pkg::value_t                 north;
    hsc_pkg::value_t                 middle;
    hsc_pkg::value_t                 cprior;
    logic [hsc_pkg::SUM_BITS-1:0]    sum4;
    hsc_pkg::value_t                 nv;
    logic [hsc_pkg::HEAT_BITS-1:0]   heat_base;
    logic [hsc_pkg::HEAT_BITS:0]     heat_sum;

    // Handshake: each stage moves when the next one is empty or moving.
    assign ready_out = !out_valid_reg || !out_stall;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign in_stall  = !ready1;
    assign accept    = in_valid && ready1;
    assign adv1      = v1_reg && ready2;
    assign out_load  = v3_reg && ready_out;

    // Entry c holds {row above, row middle, prior row}; a second copy of the
    // middle row is read one column ahead for the east neighbour.
    assign m_raddr = hsc_pkg::COL_BITS'({1'b0, pos.col} + (hsc_pkg::COL_BITS+1)'(1));
    assign e_wdata = {middle, old1_reg, prior1_reg};

    hsc_ram #(
        .WIDTH (hsc_pkg::ENTRY_BITS),
        .DEPTH (hsc_pkg::LINE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (pos1_reg.col),
        .wdata (e_wdata),
        .re    (accept),
        .raddr (pos.col),
        .rdata (e_rdata)
    );

    hsc_ram #(
        .WIDTH (hsc_pkg::VALUE_BITS),
        .DEPTH (hsc_pkg::LINE_DEPTH)
    ) u_east_ram (
        .clk   (clk),
        .we    (adv1),
        .waddr (pos1_reg.col),
        .wdata (old1_reg),
        .re    (accept),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // Neighbour sum: north from the row above, west from the middle row entry
    // read by the previous word, east one column ahead, south is the new word.
    always_comb
    begin
        north  = e_rdata[3*hsc_pkg::VALUE_BITS-1:2*hsc_pkg::VALUE_BITS];
        middle = e_rdata[2*hsc_pkg::VALUE_BITS-1:hsc_pkg::VALUE_BITS];
        cprior = e_rdata[hsc_pkg::VALUE_BITS-1:0];
        sum4   = hsc_pkg::SUM_BITS'(north) + hsc_pkg::SUM_BITS'(old1_reg) +
                 hsc_pkg::SUM_BITS'(m_rdata) + hsc_pkg::SUM_BITS'(west_reg);
    end

    // New value: half the prior plus an eighth of the neighbour sum.
    assign nv = hsc_pkg::VALUE_BITS'({1'b0, cprior2_reg[hsc_pkg::VALUE_BITS-1:1]} +
                hsc_pkg::VALUE_BITS'(sum2_reg[hsc_pkg::SUM_BITS-1:3]));

    // Heat accumulation restarts at the first interior point and saturates.
    always_comb
    begin
        heat_base = restart3_reg ? '0 : heat_reg;
        heat_sum  = {1'b0, heat_base} + (hsc_pkg::HEAT_BITS+1)'(nv3_reg);
    end

    // Pipeline valid bits and the heat accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            heat_reg      <= '0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg && pos1_reg.interior;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= v3_reg;
            end
            if (out_load)
            begin
                heat_reg <= heat_sum[hsc_pkg::HEAT_BITS] ? '1 :
                            heat_sum[hsc_pkg::HEAT_BITS-1:0];
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos1_reg   <= pos;
            old1_reg   <= old_value;
            prior1_reg <= prior_value;
        end
        if (adv1)
        begin
            west_reg     <= middle;
            sum2_reg     <= sum4;
            cprior2_reg  <= cprior;
            last2_reg    <= pos1_reg.last;
            restart2_reg <= pos1_reg.restart;
        end
        if (v2_reg && ready3)
        begin
            nv3_reg      <= nv;
            last3_reg    <= last2_reg;
            restart3_reg <= restart2_reg;
        end
        if (out_load)
        begin
            new_value_reg <= nv3_reg;
            last_reg      <= last3_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign heat_total = heat_reg;
    assign last_point = last_reg;

`ifndef ASSERT_OFF
    // A write-back never collides with a read of the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv1 && accept) |-> (pos1_reg.col != pos.col))
        else $error("entry RAM read and write hit the same entry");

    // The east copy is never read at the entry being written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv1 && accept) |-> (pos1_reg.col != m_raddr))
        else $error("east RAM read and write hit the same entry");

    // Read data of a waiting word is never overwritten by a new read.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!v1_reg || ready2))
        else $error("line buffer read while stage one holds");

    // Without a frame restart the heat total never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !restart3_reg) |=> (heat_reg >= $past(heat_reg)))
        else $error("heat total decreased within a frame");
`endif

endmodule

`default_nettype wire

@@ rtl/core/five_point_heat_stencil_core.sv @@
// Top level of the five-point heat stencil core.
//
//   channel   direction   handshake              payload
//   in        to core     in_valid / in_stall    old_value, prior_value
//   out       from core   out_valid / out_stall  new_value, heat_total, last_point
//   cfg       to core     cfg_we                 cfg_index, cfg_data
//
// One word is accepted per cycle while the input is not stalled. A result is presented
// once the word completing its stencil has passed the line buffer read, the neighbour
// sum, the new value and the output register, which are one stage each.
// Reset clears the counters, the heat total and the pipeline; the line buffers
// are not cleared and hold valid data once the first rows have streamed through.
// A stall on the output holds the output register; the input is stalled only
// when every pipeline stage ahead of it is full.
`default_nettype none

module five_point_heat_stencil_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [hsc_pkg::VALUE_BITS-1:0]        old_value,
    input  wire logic [hsc_pkg::VALUE_BITS-1:0]        prior_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [hsc_pkg::VALUE_BITS-1:0]             new_value,
    output logic [hsc_pkg::HEAT_BITS-1:0]              heat_total,
    output logic                                       last_point,
    input  wire logic                                  cfg_we,
    input  wire logic [hsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [hsc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    hsc_pkg::pos_t pos;
    logic          accept;

    // A word is taken when valid and not stalled.
    assign accept = in_valid && !in_stall;

    // Position sequencer and configuration.
    hsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos)
    );

    // Line buffers and arithmetic.
    hsc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .old_value   (old_value),
        .prior_value (prior_value),
        .pos         (pos),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_value   (new_value),
        .heat_total  (heat_total),
        .last_point  (last_point)
    );

endmodule

`default_nettype wire
